### src/fvm_pkg.sv
package fvm_pkg;

    // Field widths of the stream words
    localparam int OP_W  = 2;
    localparam int ID_W  = 4;
    localparam int VAL_W = 64;
    localparam int LEN_W = 7;

    // Number of entries addressable through entry_id
    localparam int ID_SPACE = 16;

    // Packed word widths, rounded up to whole bytes
    localparam int IN_ITEM_W   = OP_W + ID_W + VAL_W + LEN_W;
    localparam int IN_TDATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
    localparam int OUT_ITEM_W  = 1 + VAL_W + LEN_W + VAL_W;
    localparam int OUT_TDATA_W = ((OUT_ITEM_W + 7) / 8) * 8;

    // Opcodes
    localparam logic [OP_W-1:0] OP_INC    = 2'd0;
    localparam logic [OP_W-1:0] OP_TX     = 2'd1;
    localparam logic [OP_W-1:0] OP_RX     = 2'd2;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd3;

    // Result status codes
    localparam logic ST_ACCEPT = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    // Input word, last field in the low bits
    typedef struct packed {
        logic [LEN_W-1:0] length_bits;
        logic [VAL_W-1:0] value_in;
        logic [ID_W-1:0]  entry_id;
        logic [OP_W-1:0]  opcode;
    } t_in_item;

    // Result word, last field in the low bits
    typedef struct packed {
        logic [VAL_W-1:0] trunc_value;
        logic [LEN_W-1:0] full_length;
        logic [VAL_W-1:0] full_value;
        logic             status;
    } t_out_item;

    // Sequencer commands to the datapath
    typedef struct packed {
        logic capture;
        logic load;
        logic merge;
        logic resolve;
        logic commit;
    } t_ctl_cmd;

    // Number of bytes covering a bit length (0..16)
    function automatic logic [4:0] bytes_of(input logic [LEN_W-1:0] bits);
        logic [7:0] sum;
        sum = {1'b0, bits} + 8'd7;
        return sum[7:3];
    endfunction

    // Mask of the low nbytes bytes of a value
    function automatic logic [VAL_W-1:0] byte_mask(input logic [3:0] nbytes);
        logic [VAL_W-1:0] m;
        if (nbytes >= 4'd8) begin
            m = '1;
        end else begin
            m = (64'd1 << {nbytes, 3'b000}) - 64'd1;
        end
        return m;
    endfunction

endpackage

### src/fvm_ctrl.sv
module fvm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output fvm_pkg::t_ctl_cmd o_cmd
);
    import fvm_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LOAD    = 3'd1;
    localparam logic [2:0] S_MERGE   = 3'd2;
    localparam logic [2:0] S_RESOLVE = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_m_valid, n_m_valid;
    logic       accept, commit;

    assign o_s_ready = (r_state == S_IDLE);
    assign accept    = i_s_valid && o_s_ready;
    // result goes out once the output register is free or being drained
    assign commit    = (r_state == S_DONE) && (!r_m_valid || i_m_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (accept) n_state = S_LOAD;
            S_LOAD:    n_state = S_MERGE;
            S_MERGE:   n_state = S_RESOLVE;
            S_RESOLVE: n_state = S_DONE;
            S_DONE:    if (commit) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // output valid flag
    always_comb begin
        n_m_valid = r_m_valid;
        if (commit) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_valid     = r_m_valid;
    assign o_cmd.capture = accept;
    assign o_cmd.load    = (r_state == S_LOAD);
    assign o_cmd.merge   = (r_state == S_MERGE);
    assign o_cmd.resolve = (r_state == S_RESOLVE);
    assign o_cmd.commit  = commit;

endmodule

### src/fvm_datapath.sv
module fvm_datapath #(
    parameter int NUM_IDS        = 16,
    parameter int MAX_FRESH_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fvm_pkg::t_ctl_cmd  i_cmd,
    input  fvm_pkg::t_in_item  i_item,
    output fvm_pkg::t_out_item o_item
);
    import fvm_pkg::*;

    localparam int DEPTH = (NUM_IDS < ID_SPACE) ? NUM_IDS : ID_SPACE;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRESH_BITS);

    // table: seen bit doubles as entry valid
    logic [VAL_W-1:0] r_cnt_mem [DEPTH];
    logic [LEN_W-1:0] r_len_mem [DEPTH];
    logic [DEPTH-1:0] r_seen;

    // captured word and table read data
    t_in_item         r_in;
    logic [VAL_W-1:0] r_cnt_rd;
    logic [LEN_W-1:0] r_len_rd;

    // load stage
    logic             r_inr, r_seen_e;
    logic [VAL_W-1:0] r_cnt, r_fmask, r_stored, r_tmask, r_uval;
    logic [LEN_W-1:0] r_rawlen, r_flen, r_ulen, r_uflen;
    logic [3:0]       r_fbytes, r_tb;

    // merge stage
    logic [VAL_W-1:0] r_inc, r_merge, r_cand_full, r_trunc;
    logic             r_full_gt, r_merge_gt, r_roll_ok, r_bad_len, r_eq_len;

    // resolve stage
    t_out_item        r_res;
    logic             r_wen;
    logic [VAL_W-1:0] r_wcnt;
    logic [LEN_W-1:0] r_wlen;

    t_out_item        r_out;

    // load stage logic
    logic [IDX_W-1:0] idx, rd_idx;
    logic             inr, seen_e;
    logic [VAL_W-1:0] cnt_e, fmask, tmask, umask;
    logic [LEN_W-1:0] len_e, flen, lsat, uflen;
    logic [3:0]       fbytes, tb, ubytes;
    logic [4:0]       fb5, tb5, ub5;

    assign rd_idx = i_item.entry_id[IDX_W-1:0];
    assign idx    = r_in.entry_id[IDX_W-1:0];
    assign inr    = ({7'd0, r_in.entry_id} < 11'(NUM_IDS));
    assign seen_e = inr && r_seen[idx];
    assign cnt_e  = seen_e ? r_cnt_rd : '0;
    assign len_e  = seen_e ? r_len_rd : '0;
    assign flen   = (len_e == '0 || len_e > LEN_MAX) ? LEN_MAX : len_e;
    assign fb5    = bytes_of(flen);
    assign fbytes = fb5[3:0];
    assign fmask  = byte_mask(fbytes);
    assign tb5    = bytes_of(r_in.length_bits);
    assign tb     = (tb5 > {1'b0, fbytes}) ? fbytes : tb5[3:0];
    assign tmask  = byte_mask(tb);
    assign lsat   = (r_in.length_bits > LEN_MAX) ? LEN_MAX : r_in.length_bits;
    assign uflen  = (lsat == '0) ? LEN_MAX : lsat;
    assign ub5    = bytes_of(uflen);
    assign ubytes = ub5[3:0];
    assign umask  = byte_mask(ubytes);

    // resolve stage logic
    logic [VAL_W-1:0] step, rolled;
    logic             rolled_gt, rx_ok;
    logic [VAL_W-1:0] rx_cand;
    t_out_item        res;
    logic             wen;
    logic [VAL_W-1:0] wcnt;
    logic [LEN_W-1:0] wlen;

    assign step      = (r_tb < 4'd8) ? (64'd1 << {r_tb, 3'b000}) : '0;
    assign rolled    = (r_merge + step) & r_fmask;
    assign rolled_gt = rolled > r_stored;

    always_comb begin
        rx_ok   = 1'b0;
        rx_cand = r_merge;
        if (r_bad_len) begin
            rx_ok = 1'b0;
        end else if (r_eq_len) begin
            rx_cand = r_cand_full;
            rx_ok   = !r_seen_e || r_full_gt;
        end else if (!r_seen_e || r_merge_gt) begin
            rx_ok = 1'b1;
        end else if (r_roll_ok && rolled_gt) begin
            rx_cand = rolled;
            rx_ok   = 1'b1;
        end
    end

    // result selection and table write-back values
    always_comb begin
        res             = '0;
        res.status      = ST_REJECT;
        wen             = 1'b0;
        wcnt            = r_inc;
        wlen            = r_rawlen;
        if (r_inr) begin
            case (r_in.opcode)
                OP_INC: begin
                    res.status      = ST_ACCEPT;
                    res.full_value  = r_inc & r_fmask;
                    res.full_length = r_flen;
                    wen             = 1'b1;
                end
                OP_TX: begin
                    res.status      = ST_ACCEPT;
                    res.full_value  = r_stored;
                    res.full_length = r_flen;
                    res.trunc_value = r_trunc;
                end
                OP_RX: begin
                    if (rx_ok) begin
                        res.status      = ST_ACCEPT;
                        res.full_value  = rx_cand;
                        res.full_length = r_flen;
                    end
                end
                default: begin
                    res.status      = ST_ACCEPT;
                    res.full_value  = r_uval;
                    res.full_length = r_uflen;
                    wen             = 1'b1;
                    wcnt            = r_uval;
                    wlen            = r_ulen;
                end
            endcase
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in     <= i_item;
            r_cnt_rd <= r_cnt_mem[rd_idx];
            r_len_rd <= r_len_mem[rd_idx];
        end
        if (i_cmd.load) begin
            r_inr    <= inr;
            r_seen_e <= seen_e;
            r_cnt    <= cnt_e;
            r_rawlen <= len_e;
            r_flen   <= flen;
            r_fbytes <= fbytes;
            r_fmask  <= fmask;
            r_stored <= cnt_e & fmask;
            r_tb     <= tb;
            r_tmask  <= tmask;
            r_ulen   <= lsat;
            r_uflen  <= uflen;
            r_uval   <= r_in.value_in & umask;
        end
        if (i_cmd.merge) begin
            r_inc       <= r_cnt + 64'd1;
            r_merge     <= (r_stored & ~r_tmask) | (r_in.value_in & r_tmask);
            r_cand_full <= r_in.value_in & r_fmask;
            r_trunc     <= r_stored & r_tmask;
            r_full_gt   <= (r_in.value_in & r_fmask) > r_stored;
            r_merge_gt  <= ((r_stored & ~r_tmask) | (r_in.value_in & r_tmask)) > r_stored;
            r_roll_ok   <= (r_tb < r_fbytes) && ((r_stored & r_tmask) == r_tmask)
                           && ((r_in.value_in & r_tmask) == '0);
            r_bad_len   <= (r_in.length_bits == '0) || (r_in.length_bits > r_flen);
            r_eq_len    <= (r_in.length_bits == r_flen);
        end
        if (i_cmd.resolve) begin
            r_res  <= res;
            r_wen  <= wen;
            r_wcnt <= wcnt;
            r_wlen <= wlen;
        end
        if (i_cmd.commit) begin
            r_out <= r_res;
            if (r_wen) begin
                r_cnt_mem[idx] <= r_wcnt;
                r_len_mem[idx] <= r_wlen;
            end
        end
    end

    // seen flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_cmd.commit && r_wen) begin
            r_seen[idx] <= 1'b1;
        end
    end

    assign o_item = r_out;

endmodule

### src/freshness_value_manager_core.sv
// Freshness value manager: per-ID freshness counter table with four opcodes.
// Each input word passes through capture and table read, length decode,
// merge/compare, rollover add/compare and write-back; no new word is accepted
// until its result enters the output register, which a stalled output delays.
// Reset (i_rst_n low, synchronous) clears all seen flags, so every entry reads
// as zero value and zero length, and empties the output register.
module freshness_value_manager_core #(
    parameter int NUM_IDS        = 16,
    parameter int MAX_FRESH_BITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // opcode[1:0], entry_id[5:2], value_in[69:6], length_bits[76:70], zero pad
    input  logic [fvm_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // status[0], full_value[64:1], full_length[71:65], trunc_value[135:72]
    output logic [fvm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import fvm_pkg::*;

    t_ctl_cmd  cmd;
    t_in_item  in_item;
    t_out_item out_item;

    assign in_item = t_in_item'(i_s_axis_tdata[IN_ITEM_W-1:0]);

    fvm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_cmd     (cmd)
    );

    fvm_datapath #(
        .NUM_IDS        (NUM_IDS),
        .MAX_FRESH_BITS (MAX_FRESH_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (in_item),
        .o_item  (out_item)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'(out_item);

endmodule
